@@ hdl/svg_pkg.sv @@
package svg_pkg;

   // Field and register widths.
   localparam int CountW   = 9;
   localparam int IdxW     = 9;
   localparam int MaxSeg   = 256;
   localparam int AngleW   = 16;
   localparam int QuotW    = 18;
   localparam int TrigW    = 31;
   localparam int RadiusW  = 16;
   localparam int PosW     = 17;
   localparam int NormW    = 16;
   localparam int TexW     = 16;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 136;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 16;

   // Register indexes on the configuration port.
   localparam logic [CsrAddrW-1:0] RegRadius       = 3'd0;
   localparam logic [CsrAddrW-1:0] RegSectorCount  = 3'd1;
   localparam logic [CsrAddrW-1:0] RegStackCount   = 3'd2;
   localparam logic [CsrAddrW-1:0] RegNormalEnable = 3'd3;
   localparam logic [CsrAddrW-1:0] RegUvEnable     = 3'd4;

   // One in Q30 and the sin(pi z / 2) Taylor coefficients in Q30.
   localparam logic [TrigW-1:0] Q30One = 31'h4000_0000;
   localparam logic [TrigW-1:0] CoefC1 = 31'd1686629713;
   localparam logic [TrigW-1:0] CoefC3 = 31'd693598668;
   localparam logic [TrigW-1:0] CoefC5 = 31'd85569306;
   localparam logic [TrigW-1:0] CoefC7 = 31'd5026995;
   localparam logic [TrigW-1:0] CoefC9 = 31'd172272;

   // Side data that rides along the trig pipeline.
   typedef struct packed {
      logic [TexW-1:0] tex_s;
      logic [TexW-1:0] tex_t;
      logic [1:0]      quad_e;
      logic [1:0]      quad_a;
   } side_type;

   // A count of zero acts as one, a count above the maximum is capped.
   function automatic logic [CountW-1:0] eff_count(logic [CountW-1:0] c);
      if (c == '0) begin
         return CountW'(1);
      end
      if (c > CountW'(MaxSeg)) begin
         return CountW'(MaxSeg);
      end
      return c;
   endfunction

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [CountW:0] div_step(logic [CountW-1:0] r,
                                                logic [CountW-1:0] den);
      logic [CountW:0] r2;
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, den}) begin
         return {1'b1, CountW'(r2 - {1'b0, den})};
      end
      return {1'b0, r2[CountW-1:0]};
   endfunction

   // Product of two Q30 values, truncated back to Q30.
   function automatic logic [TrigW-1:0] mul_q30(logic [TrigW-1:0] a, logic [TrigW-1:0] b);
      logic [2*TrigW-1:0] p;
      p = a * b;
      return p[60:30];
   endfunction

   // Product of two Q30 values, rounded half up back to Q30.
   function automatic logic [TrigW-1:0] rmul_q30(logic [TrigW-1:0] a, logic [TrigW-1:0] b);
      logic [2*TrigW-1:0] p;
      p = a * b + 62'(1 << 29);
      return p[60:30];
   endfunction

endpackage

@@ hdl/svg_div.sv @@
// Fractional divider: quot = floor(num * 2^17 / den) for num <= den.
// Three register stages of six quotient bits each.
module svg_div
   import svg_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [IdxW-1:0]   num,
   input  logic [CountW-1:0] den,
   output logic [QuotW-1:0]  quot
);

   logic [5:0]        qa_in, qa_ff;
   logic [CountW-1:0] ra_in, ra_ff;
   logic [11:0]       qb_in, qb_ff;
   logic [CountW-1:0] rb_in, rb_ff;
   logic [17:0]       qc_in, qc_ff;

   // First stage: integer bit and five fraction bits.
   always_comb begin
      logic [CountW:0]   step;
      logic [CountW-1:0] r;
      qa_in[5] = (num == den);
      r = (num == den) ? '0 : num;
      for (int i = 4; i >= 0; i--) begin
         step = div_step(r, den);
         qa_in[i] = step[CountW];
         r = step[CountW-1:0];
      end
      ra_in = r;
   end

   // Second stage: six more fraction bits.
   always_comb begin
      logic [CountW:0]   step;
      logic [CountW-1:0] r;
      r = ra_ff;
      qb_in[11:6] = qa_ff;
      for (int i = 5; i >= 0; i--) begin
         step = div_step(r, den);
         qb_in[i] = step[CountW];
         r = step[CountW-1:0];
      end
      rb_in = r;
   end

   // Third stage: the last six fraction bits.
   always_comb begin
      logic [CountW:0]   step;
      logic [CountW-1:0] r;
      r = rb_ff;
      qc_in[17:6] = qb_ff;
      for (int i = 5; i >= 0; i--) begin
         step = div_step(r, den);
         qc_in[i] = step[CountW];
         r = step[CountW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qa_ff <= qa_in;
         ra_ff <= ra_in;
         qb_ff <= qb_in;
         rb_ff <= rb_in;
         qc_ff <= qc_in;
      end
   end

   assign quot = qc_ff;

endmodule

@@ hdl/svg_qsin.sv @@
// Quarter-wave sine sin(pi z / 2), z in Q30 from 0 to one inclusive.
// Horner evaluation, one multiply per register stage, six stages.
module svg_qsin
   import svg_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [TrigW-1:0] z,
   output logic [TrigW-1:0] s
);

   logic [TrigW-1:0] z_ff  [1:5];
   logic [TrigW-1:0] z2_ff [1:4];
   logic [TrigW-1:0] t_ff  [2:5];
   logic [TrigW-1:0] s_in, s_ff;
   logic [TrigW-1:0] prod;

   // Final multiply and clamp to one.
   always_comb begin
      prod = mul_q30(z_ff[5], t_ff[5]);
      s_in = (prod > Q30One) ? Q30One : prod;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[1]  <= z;
         z2_ff[1] <= mul_q30(z, z);
         for (int i = 2; i <= 5; i++) begin
            z_ff[i] <= z_ff[i-1];
         end
         for (int i = 2; i <= 4; i++) begin
            z2_ff[i] <= z2_ff[i-1];
         end
         t_ff[2] <= CoefC7 - mul_q30(z2_ff[1], CoefC9);
         t_ff[3] <= CoefC5 - mul_q30(z2_ff[2], t_ff[2]);
         t_ff[4] <= CoefC3 - mul_q30(z2_ff[3], t_ff[3]);
         t_ff[5] <= CoefC1 - mul_q30(z2_ff[4], t_ff[4]);
         s_ff    <= s_in;
      end
   end

   assign s = s_ff;

endmodule

@@ hdl/svg_ofifo.sv @@
// Two-entry output queue that decouples the pipeline from the result channel.
module svg_ofifo
   import svg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [RspDataW-1:0] push_data,
   input  logic                pop,
   output logic                out_valid,
   output logic [RspDataW-1:0] out_data,
   output logic [1:0]          level
);

   logic [RspDataW-1:0] mem_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign level     = cnt_ff;

endmodule

@@ hdl/sphere_vertex_generator_unit.sv @@
// Throughput: one item per cycle; 13 pipeline stages (index clamp, three divider
// stages, phase setup, six Horner multiply stages, two scaling stages) feed a
// two-entry output queue. The item is stalled only when that queue is full.
// Reset clears the valid bits, the queue and loads the register defaults.
module sphere_vertex_generator_unit
   import svg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // stack_index[8:0], sector_index[17:9], zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, zero pad
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int Stages = 13;

   logic [RadiusW-1:0] radius_ff;
   logic [CountW-1:0]  sector_count_ff, stack_count_ff;
   logic               normal_enable_ff, uv_enable_ff;
   logic [CountW-1:0]  sectors, stacks;

   logic               en;
   logic [Stages-1:0]  v_ff;
   logic [1:0]         fifo_level;

   logic [IdxW-1:0]    sec_ff, stk_ff, sec_in, stk_in;
   logic [QuotW-1:0]   q_sec, q_stk;

   logic [AngleW-1:0]  phase_e_ff, phase_a_ff, phase_e_in, phase_a_in;
   side_type           side_in;
   side_type           side_ff [0:6];

   logic [TrigW-1:0]   z_ea, z_eb, z_aa, z_ab;
   logic [TrigW-1:0]   s_ea, s_eb, s_aa, s_ab;

   logic [TrigW-1:0]   se_mag, ce_mag, sa_mag, ca_mag;
   logic               se_neg, ce_neg, sa_neg, ca_neg;
   logic [TrigW-1:0]   nx_ff, ny_ff, nz_ff;
   logic               nx_neg_ff, ny_neg_ff, nz_neg_ff;
   logic [TexW-1:0]    tex_s1_ff, tex_t1_ff;

   logic [RadiusW-1:0] px_mag_ff, py_mag_ff, pz_mag_ff;
   logic [NormW-2:0]   nx_mag_ff, ny_mag_ff, nz_mag_ff;
   logic               px_neg_ff, py_neg_ff, pz_neg_ff;
   logic [TexW-1:0]    tex_s2_ff, tex_t2_ff;

   logic [PosW-1:0]    pos_x, pos_y, pos_z;
   logic [NormW-1:0]   norm_x, norm_y, norm_z;
   logic [TexW-1:0]    tex_s, tex_t;
   logic [RspDataW-1:0] push_data;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff        <= RadiusW'(256);
         sector_count_ff  <= CountW'(16);
         stack_count_ff   <= CountW'(8);
         normal_enable_ff <= 1'b1;
         uv_enable_ff     <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_addr)
            RegRadius:       radius_ff        <= csr_wdata;
            RegSectorCount:  sector_count_ff  <= csr_wdata[CountW-1:0];
            RegStackCount:   stack_count_ff   <= csr_wdata[CountW-1:0];
            RegNormalEnable: normal_enable_ff <= csr_wdata[0];
            RegUvEnable:     uv_enable_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Counts are used directly at every stage; the user must change them only while idle (not enforced by the block).
   assign sectors = eff_count(sector_count_ff);
   assign stacks  = eff_count(stack_count_ff);

   // The pipeline advances unless the output queue is full and not draining.
   assign en         = (fifo_level != 2'd2) || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[Stages-2:0], req_tvalid};
      end
   end

   // Stage 0: clamp the indices to their counts.
   always_comb begin
      stk_in = req_tdata[8:0];
      sec_in = req_tdata[17:9];
      if (stk_in > stacks) begin
         stk_in = stacks;
      end
      if (sec_in > sectors) begin
         sec_in = sectors;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stk_ff <= stk_in;
         sec_ff <= sec_in;
      end
   end

   // Stages 1 to 3: index over count as a 17-bit fraction.
   svg_div u_div_sec (
      .clock (clock),
      .en    (en),
      .num   (sec_ff),
      .den   (sectors),
      .quot  (q_sec)
   );

   svg_div u_div_stk (
      .clock (clock),
      .en    (en),
      .num   (stk_ff),
      .den   (stacks),
      .quot  (q_stk)
   );

   // Stage 4: round the fractions into phases and texture coordinates.
   always_comb begin
      logic [QuotW:0]   az_sum;
      logic [QuotW-1:0] ts_sum, tt_sum;
      az_sum        = {1'b0, q_sec} + (QuotW+1)'(1);
      ts_sum        = {1'b0, q_sec[QuotW-1:1]} + QuotW'(1);
      tt_sum        = {1'b0, q_stk[QuotW-1:1]} + QuotW'(1);
      phase_a_in    = az_sum[AngleW:1];
      side_in.tex_s = ts_sum[TexW:1];
      side_in.tex_t = tt_sum[TexW:1];
      phase_e_in    = AngleW'(1 << (AngleW - 2)) - side_in.tex_t;
      side_in.quad_e = phase_e_in[AngleW-1:AngleW-2];
      side_in.quad_a = phase_a_in[AngleW-1:AngleW-2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_e_ff <= phase_e_in;
         phase_a_ff <= phase_a_in;
         side_ff[0] <= side_in;
         for (int i = 1; i <= 6; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Stages 5 to 10: quarter-wave sine at z and at one minus z for both angles.
   assign z_ea = {1'b0, phase_e_ff[AngleW-3:0], 16'b0};
   assign z_eb = Q30One - z_ea;
   assign z_aa = {1'b0, phase_a_ff[AngleW-3:0], 16'b0};
   assign z_ab = Q30One - z_aa;

   svg_qsin u_qsin_ea (.clock(clock), .en(en), .z(z_ea), .s(s_ea));
   svg_qsin u_qsin_eb (.clock(clock), .en(en), .z(z_eb), .s(s_eb));
   svg_qsin u_qsin_aa (.clock(clock), .en(en), .z(z_aa), .s(s_aa));
   svg_qsin u_qsin_ab (.clock(clock), .en(en), .z(z_ab), .s(s_ab));

   // Stage 11: quadrant symmetry, then the cos products.
   always_comb begin
      se_mag = side_ff[6].quad_e[0] ? s_eb : s_ea;
      ce_mag = side_ff[6].quad_e[0] ? s_ea : s_eb;
      se_neg = side_ff[6].quad_e[1];
      ce_neg = side_ff[6].quad_e[1] ^ side_ff[6].quad_e[0];
      sa_mag = side_ff[6].quad_a[0] ? s_ab : s_aa;
      ca_mag = side_ff[6].quad_a[0] ? s_aa : s_ab;
      sa_neg = side_ff[6].quad_a[1];
      ca_neg = side_ff[6].quad_a[1] ^ side_ff[6].quad_a[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff     <= rmul_q30(ce_mag, ca_mag);
         ny_ff     <= rmul_q30(ce_mag, sa_mag);
         nz_ff     <= se_mag;
         nx_neg_ff <= ce_neg ^ ca_neg;
         ny_neg_ff <= ce_neg ^ sa_neg;
         nz_neg_ff <= se_neg;
         tex_s1_ff <= side_ff[6].tex_s;
         tex_t1_ff <= side_ff[6].tex_t;
      end
   end

   // Stage 12: scale by the radius and round the normal to Q1.14.
   always_ff @(posedge clock) begin
      logic [46:0] px, py, pz;
      logic [31:0] rx, ry, rz;
      if (en) begin
         px = radius_ff * nx_ff + 47'(1 << 29);
         py = radius_ff * ny_ff + 47'(1 << 29);
         pz = radius_ff * nz_ff + 47'(1 << 29);
         rx = {1'b0, nx_ff} + 32'(1 << 15);
         ry = {1'b0, ny_ff} + 32'(1 << 15);
         rz = {1'b0, nz_ff} + 32'(1 << 15);
         px_mag_ff <= px[45:30];
         py_mag_ff <= py[45:30];
         pz_mag_ff <= pz[45:30];
         nx_mag_ff <= rx[30:16];
         ny_mag_ff <= ry[30:16];
         nz_mag_ff <= rz[30:16];
         px_neg_ff <= nx_neg_ff;
         py_neg_ff <= ny_neg_ff;
         pz_neg_ff <= nz_neg_ff;
         tex_s2_ff <= tex_s1_ff;
         tex_t2_ff <= tex_t1_ff;
      end
   end

   // Two's complement encoding and the enable gates.
   always_comb begin
      pos_x  = px_neg_ff ? PosW'(-{1'b0, px_mag_ff}) : {1'b0, px_mag_ff};
      pos_y  = py_neg_ff ? PosW'(-{1'b0, py_mag_ff}) : {1'b0, py_mag_ff};
      pos_z  = pz_neg_ff ? PosW'(-{1'b0, pz_mag_ff}) : {1'b0, pz_mag_ff};
      norm_x = '0;
      norm_y = '0;
      norm_z = '0;
      tex_s  = '0;
      tex_t  = '0;
      if (normal_enable_ff) begin
         norm_x = px_neg_ff ? NormW'(-{1'b0, nx_mag_ff}) : {1'b0, nx_mag_ff};
         norm_y = py_neg_ff ? NormW'(-{1'b0, ny_mag_ff}) : {1'b0, ny_mag_ff};
         norm_z = pz_neg_ff ? NormW'(-{1'b0, nz_mag_ff}) : {1'b0, nz_mag_ff};
      end
      if (uv_enable_ff) begin
         tex_s = tex_s2_ff;
         tex_t = tex_t2_ff;
      end
      push_data = {5'b0, tex_t, tex_s, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
   end

   svg_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push      (en && v_ff[Stages-1]),
      .push_data (push_data),
      .pop       (rsp_tvalid && rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .level     (fifo_level)
   );

   // The queue never holds more than two items.
   a_level_max: assert property (@(posedge clock) disable iff (reset)
      fifo_level != 2'd3)
      else $error("output queue overflow");

   // Input is held back only when the queue is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> fifo_level == 2'd2)
      else $error("input stalled with room in the queue");

   // Disabled normals read as zero.
   a_norm_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !normal_enable_ff) |-> rsp_tdata[98:51] == '0)
      else $error("normal fields not zero while disabled");

   // Disabled texture coordinates read as zero.
   a_tex_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !uv_enable_ff) |-> rsp_tdata[130:99] == '0)
      else $error("texture fields not zero while disabled");

endmodule
